/* hw/rtl/lsg_pkg.sv */
// Shared types and constants for the line-of-sight grid check block.
// Used by lsg_cell, lsg_root, lsg_div and line_of_sight_grid_check_core.
// No dependencies.
package lsg_pkg;

    localparam int CELL_BITS = 8;
    localparam int FRAC_BITS = 8;
    localparam int POS_W     = CELL_BITS + FRAC_BITS;
    localparam int OBS_W     = 2 * CELL_BITS;
    localparam int STEP_W    = 8;
    localparam int ROOT_W    = POS_W + 1;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int DVD_W     = POS_W + STEP_W;

    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(26);

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_CLEAR = 2'd1,
        MODE_QUERY = 2'd2
    } mode_t;

    // One sample point travelling down the obstacle chain.
    typedef struct packed {
        logic             vld;
        logic             hit;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } pt_t;

endpackage

/* hw/rtl/line_of_sight_grid_check_core.sv */
// Load and clear transactions complete on acceptance. A query runs 17 square-root and
// 24 divider iterations, then issues one sample point a cycle into the obstacle chain,
// then lets the chain drain. A blocked point ends the march early; out of range or zero
// distance skips the divider and the march.
// One transaction at a time. Reset (asynchronous, active low) empties the obstacle table
// and sets the step to 26; the obstacle cells themselves are not cleared.
module line_of_sight_grid_check_core #(
    parameter int MAX_OBSTACLES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] cell_x, [15:8] cell_y, [31:16] from_x, [47:32] from_y,
    // [63:48] to_x, [79:64] to_y, [95:80] reach
    input  logic [95:0] s_tdata,
    // [1:0] mode
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] shot_clear, upper bits zero
    output logic [7:0]  m_tdata,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    localparam int POS_W  = lsg_pkg::POS_W;
    localparam int ROOT_W = lsg_pkg::ROOT_W;
    localparam int DVD_W  = lsg_pkg::DVD_W;
    localparam int OBS_W  = lsg_pkg::OBS_W;
    localparam int STEP_W = lsg_pkg::STEP_W;
    localparam int CNT_W  = $clog2(MAX_OBSTACLES + 1);
    localparam int DRN_W  = $clog2(MAX_OBSTACLES + 3);
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_OBSTACLES);
    localparam logic [DRN_W-1:0] DRAIN_LEN = DRN_W'(MAX_OBSTACLES + 1);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SQUARE = 9'b000000010,
        ST_SUM    = 9'b000000100,
        ST_ROOT   = 9'b000001000,
        ST_MUL    = 9'b000010000,
        ST_DIV    = 9'b000100000,
        ST_MARCH  = 9'b001000000,
        ST_DRAIN  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [STEP_W-1:0]    step_reg;
    logic [DRN_W-1:0]     drain_reg;
    logic [DRN_W-1:0]     drain_next;
    logic                 blocked_reg;
    logic                 blocked_next;
    logic                 result_reg;
    logic                 result_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic                 shot_reg;
    logic                 shot_next;
    logic                 issue_vld_reg;
    logic                 issue_next;

    logic [POS_W-1:0]     fx_reg;
    logic [POS_W-1:0]     fy_reg;
    logic [POS_W-1:0]     reach_reg;
    logic [POS_W-1:0]     adx_reg;
    logic [POS_W-1:0]     ady_reg;
    logic                 negx_reg;
    logic                 negy_reg;
    logic [2*POS_W-1:0]   sqx_reg;
    logic [2*POS_W-1:0]   sqy_reg;
    logic [ROOT_W-1:0]    dist_reg;
    logic [ROOT_W:0]      t_reg;
    logic [DVD_W-1:0]     qx_reg;
    logic [DVD_W-1:0]     qy_reg;
    logic [ROOT_W-1:0]    rx_reg;
    logic [ROOT_W-1:0]    ry_reg;
    logic [POS_W-1:0]     issue_x_reg;
    logic [POS_W-1:0]     issue_y_reg;

    logic                 accept;
    lsg_pkg::mode_t       in_mode;
    logic [POS_W:0]       dx_full;
    logic [POS_W:0]       dy_full;
    logic [STEP_W-1:0]    step_eff;
    logic                 root_start;
    logic                 root_done;
    logic [ROOT_W-1:0]    root_val;
    logic                 div_start;
    logic                 div_done;
    logic                 div_done_y;
    logic [DVD_W-1:0]     qsx;
    logic [DVD_W-1:0]     qsy;
    logic [ROOT_W-1:0]    rsx;
    logic [ROOT_W-1:0]    rsy;
    logic                 march_init;
    logic                 shift_en;
    logic [ROOT_W:0]      rsum_x;
    logic [ROOT_W:0]      rsum_y;
    logic                 wrap_x;
    logic                 wrap_y;
    logic [ROOT_W-1:0]    rx_new;
    logic [ROOT_W-1:0]    ry_new;
    logic [POS_W-1:0]     px;
    logic [POS_W-1:0]     py;
    lsg_pkg::pt_t         issue_pt;
    lsg_pkg::pt_t         tail_pt;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign in_mode  = lsg_pkg::mode_t'(s_tuser);
    assign dx_full  = {1'b0, s_tdata[63:48]} - {1'b0, s_tdata[31:16]};
    assign dy_full  = {1'b0, s_tdata[79:64]} - {1'b0, s_tdata[47:32]};
    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;

    // Per sample, each axis advances its quotient and remainder by the per-step
    // increment; a remainder reaching the distance carries one into the quotient.
    assign rsum_x = {1'b0, rx_reg} + {1'b0, rsx};
    assign rsum_y = {1'b0, ry_reg} + {1'b0, rsy};
    assign wrap_x = (rsum_x >= {1'b0, dist_reg});
    assign wrap_y = (rsum_y >= {1'b0, dist_reg});
    assign rx_new = wrap_x ? ROOT_W'(rsum_x - {1'b0, dist_reg}) : rsum_x[ROOT_W-1:0];
    assign ry_new = wrap_y ? ROOT_W'(rsum_y - {1'b0, dist_reg}) : rsum_y[ROOT_W-1:0];

    assign px = negx_reg ? (fx_reg - qx_reg[POS_W-1:0]) : (fx_reg + qx_reg[POS_W-1:0]);
    assign py = negy_reg ? (fy_reg - qy_reg[POS_W-1:0]) : (fy_reg + qy_reg[POS_W-1:0]);

    assign march_init = (state_reg == ST_DIV) && div_done;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        drain_next    = drain_reg;
        result_next   = result_reg;
        shift_en      = 1'b0;
        root_start    = 1'b0;
        div_start     = 1'b0;
        issue_next    = 1'b0;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        shot_next     = shot_reg;
        blocked_next  = blocked_reg;

        if (march_init)
        begin
            blocked_next = 1'b0;
        end
        else if (tail_pt.vld && tail_pt.hit)
        begin
            blocked_next = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (in_mode)
                        lsg_pkg::MODE_LOAD:
                        begin
                            if (count_reg < MAX_CNT)
                            begin
                                shift_en   = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        lsg_pkg::MODE_CLEAR: count_next = '0;
                        lsg_pkg::MODE_QUERY: state_next = ST_SQUARE;
                        default: ;
                    endcase
                end
            end
            ST_SQUARE: state_next = ST_SUM;
            ST_SUM:
            begin
                root_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (dist_reg > {1'b0, reach_reg})
                begin
                    result_next = 1'b0;
                    state_next  = ST_DONE;
                end
                else if (dist_reg == '0)
                begin
                    result_next = 1'b1;
                    state_next  = ST_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MARCH;
                end
            end
            ST_MARCH:
            begin
                if ((t_reg < {1'b0, dist_reg}) && !blocked_reg)
                begin
                    issue_next = 1'b1;
                end
                else
                begin
                    drain_next = DRAIN_LEN;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg == '0)
                begin
                    result_next = ~blocked_reg;
                    state_next  = ST_DONE;
                end
                else
                begin
                    drain_next = drain_reg - DRN_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    shot_next     = result_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= lsg_pkg::STEP_RESET;
            drain_reg     <= '0;
            blocked_reg   <= 1'b0;
            result_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            shot_reg      <= 1'b0;
            issue_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            drain_reg     <= drain_next;
            blocked_reg   <= blocked_next;
            result_reg    <= result_next;
            m_tvalid_reg  <= m_tvalid_next;
            shot_reg      <= shot_next;
            issue_vld_reg <= issue_next;
            if (cfg_wr_en)
            begin
                step_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fx_reg    <= s_tdata[31:16];
            fy_reg    <= s_tdata[47:32];
            reach_reg <= s_tdata[95:80];
            negx_reg  <= dx_full[POS_W];
            negy_reg  <= dy_full[POS_W];
            adx_reg   <= dx_full[POS_W] ? POS_W'(-dx_full) : dx_full[POS_W-1:0];
            ady_reg   <= dy_full[POS_W] ? POS_W'(-dy_full) : dy_full[POS_W-1:0];
        end
        if (state_reg == ST_SQUARE)
        begin
            sqx_reg <= adx_reg * adx_reg;
            sqy_reg <= ady_reg * ady_reg;
        end
        if (root_done)
        begin
            dist_reg <= root_val;
        end
        if (march_init)
        begin
            t_reg  <= '0;
            qx_reg <= '0;
            qy_reg <= '0;
            rx_reg <= '0;
            ry_reg <= '0;
        end
        else if (issue_next)
        begin
            t_reg  <= t_reg + (ROOT_W+1)'(step_eff);
            qx_reg <= qx_reg + qsx + DVD_W'(wrap_x);
            qy_reg <= qy_reg + qsy + DVD_W'(wrap_y);
            rx_reg <= rx_new;
            ry_reg <= ry_new;
        end
        issue_x_reg <= px;
        issue_y_reg <= py;
    end

    lsg_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (lsg_pkg::SQ_W'({1'b0, sqx_reg} + {1'b0, sqy_reg})),
        .done     (root_done),
        .root     (root_val)
    );

    lsg_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DVD_W'(adx_reg) * DVD_W'(step_eff)),
        .divisor  (dist_reg),
        .done     (div_done),
        .quot     (qsx),
        .rem      (rsx)
    );

    lsg_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DVD_W'(ady_reg) * DVD_W'(step_eff)),
        .divisor  (dist_reg),
        .done     (div_done_y),
        .quot     (qsy),
        .rem      (rsy)
    );

    assign issue_pt.vld = issue_vld_reg;
    assign issue_pt.hit = 1'b0;
    assign issue_pt.x   = issue_x_reg;
    assign issue_pt.y   = issue_y_reg;

    // Loads shift into the head of the chain; sample points ripple through it.
    logic [OBS_W-1:0] obs_link [0:MAX_OBSTACLES-1];
    lsg_pkg::pt_t     pt_link  [0:MAX_OBSTACLES-1];

    genvar gi;
    generate
        for (gi = 0; gi < MAX_OBSTACLES; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                lsg_cell #(
                    .INDEX (gi),
                    .CNT_W (CNT_W)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .count    (count_reg),
                    .shift_en (shift_en),
                    .obs_in   ({s_tdata[15:8], s_tdata[7:0]}),
                    .obs_out  (obs_link[gi]),
                    .pt_in    (issue_pt),
                    .pt_out   (pt_link[gi])
                );
            end
            else
            begin : g_body
                lsg_cell #(
                    .INDEX (gi),
                    .CNT_W (CNT_W)
                ) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .count    (count_reg),
                    .shift_en (shift_en),
                    .obs_in   (obs_link[gi-1]),
                    .obs_out  (obs_link[gi]),
                    .pt_in    (pt_link[gi-1]),
                    .pt_out   (pt_link[gi])
                );
            end
        end
    endgenerate

    assign tail_pt  = pt_link[MAX_OBSTACLES-1];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0000000, shot_reg};

`ifndef ASSERT_OFF
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("obstacle count above table size");

    a_chain_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!tail_pt.vld && !issue_vld_reg))
        else $error("result presented while sample points still in the chain");

    a_count_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(count_reg))
        else $error("obstacle table changed during a query");

    a_march_dist : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARCH) |-> (dist_reg != '0 && div_done_y == 1'b0))
        else $error("march running with zero distance or divider still active");
`endif

endmodule

/* hw/rtl/lsg_cell.sv */
// One cell of the obstacle chain: holds one obstacle square and tests each passing point.
// Depends on lsg_pkg.
module lsg_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 9
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [CNT_W-1:0]          count,
    input  logic                      shift_en,
    input  logic [lsg_pkg::OBS_W-1:0] obs_in,
    output logic [lsg_pkg::OBS_W-1:0] obs_out,
    input  lsg_pkg::pt_t              pt_in,
    output lsg_pkg::pt_t              pt_out
);

    localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

    logic [lsg_pkg::OBS_W-1:0] obs_reg;
    logic                      vld_reg;
    logic                      hit_reg;
    logic                      hit_next;
    logic [lsg_pkg::POS_W-1:0] x_reg;
    logic [lsg_pkg::POS_W-1:0] y_reg;
    logic                      active;
    logic [lsg_pkg::POS_W-1:0] x_lo;
    logic [lsg_pkg::POS_W-1:0] y_lo;
    logic [lsg_pkg::POS_W:0]   x_hi;
    logic [lsg_pkg::POS_W:0]   y_hi;
    logic                      in_square;

    // Only entries below the fill count take part.
    assign active = (count > MY_INDEX);

    assign x_lo = {obs_reg[lsg_pkg::CELL_BITS-1:0], {lsg_pkg::FRAC_BITS{1'b0}}};
    assign y_lo = {obs_reg[lsg_pkg::OBS_W-1:lsg_pkg::CELL_BITS], {lsg_pkg::FRAC_BITS{1'b0}}};
    assign x_hi = {1'b0, x_lo} + (lsg_pkg::POS_W+1)'(1 << lsg_pkg::FRAC_BITS);
    assign y_hi = {1'b0, y_lo} + (lsg_pkg::POS_W+1)'(1 << lsg_pkg::FRAC_BITS);

    // Closed square, edges included.
    assign in_square = (pt_in.x >= x_lo) && ({1'b0, pt_in.x} <= x_hi)
                    && (pt_in.y >= y_lo) && ({1'b0, pt_in.y} <= y_hi);

    assign hit_next = pt_in.hit | (pt_in.vld & active & in_square);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            hit_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= pt_in.vld;
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= pt_in.x;
        y_reg <= pt_in.y;
        if (shift_en)
        begin
            obs_reg <= obs_in;
        end
    end

    assign obs_out    = obs_reg;
    assign pt_out.vld = vld_reg;
    assign pt_out.hit = hit_reg;
    assign pt_out.x   = x_reg;
    assign pt_out.y   = y_reg;

endmodule

/* hw/rtl/lsg_root.sv */
// Iterative truncated square root, one result bit per cycle.
// Depends on lsg_pkg.
module lsg_root (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lsg_pkg::SQ_W-1:0]   radicand,
    output logic                       done,
    output logic [lsg_pkg::ROOT_W-1:0] root
);

    localparam int REM_W = lsg_pkg::ROOT_W + 2;
    localparam int CW    = $clog2(lsg_pkg::ROOT_W + 1);

    logic [CW-1:0]                cnt_reg;
    logic [CW-1:0]                cnt_next;
    logic                         done_reg;
    logic                         done_next;
    logic [lsg_pkg::SQ_W-1:0]     val_reg;
    logic [REM_W-1:0]             rem_reg;
    logic [lsg_pkg::ROOT_W-1:0]   root_reg;
    logic [REM_W-1:0]             rem_sh;
    logic [REM_W-1:0]             trial;
    logic                         take;

    assign rem_sh = {rem_reg[REM_W-3:0], val_reg[lsg_pkg::SQ_W-1 -: 2]};
    assign trial  = {root_reg, 2'b01};
    assign take   = (rem_sh >= trial);

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CW'(lsg_pkg::ROOT_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            val_reg  <= {val_reg[lsg_pkg::SQ_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[lsg_pkg::ROOT_W-2:0], take};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* hw/rtl/lsg_div.sv */
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// Depends on lsg_pkg.
module lsg_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [lsg_pkg::DVD_W-1:0]  dividend,
    input  logic [lsg_pkg::ROOT_W-1:0] divisor,
    output logic                       done,
    output logic [lsg_pkg::DVD_W-1:0]  quot,
    output logic [lsg_pkg::ROOT_W-1:0] rem
);

    localparam int RW = lsg_pkg::ROOT_W + 1;
    localparam int CW = $clog2(lsg_pkg::DVD_W + 1);

    logic [CW-1:0]                cnt_reg;
    logic [CW-1:0]                cnt_next;
    logic                         done_reg;
    logic                         done_next;
    logic [lsg_pkg::DVD_W-1:0]    dvd_reg;
    logic [lsg_pkg::ROOT_W-1:0]   dsr_reg;
    logic [lsg_pkg::ROOT_W-1:0]   rem_reg;
    logic [RW-1:0]                rem_sh;
    logic                         take;
    logic [RW-1:0]                rem_sub;

    assign rem_sh  = {rem_reg, dvd_reg[lsg_pkg::DVD_W-1]};
    assign take    = (rem_sh >= {1'b0, dsr_reg});
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next = CW'(lsg_pkg::DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - CW'(1);
            done_next = (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    // The dividend register shifts out from the top while quotient bits enter below.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[lsg_pkg::DVD_W-2:0], take};
            rem_reg <= take ? rem_sub[lsg_pkg::ROOT_W-1:0] : rem_sh[lsg_pkg::ROOT_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = dvd_reg;
    assign rem  = rem_reg;

endmodule

/* bench/lsg_sight_checker.sv */
// Checker for the line-of-sight grid check core: follows the input, output and register
// ports, predicts each shot_clear answer and compares it with what the block returns.
// Depends on lsg_pkg for the field widths, the step reset value and the mode codes.
`timescale 1ns / 100ps

module lsg_sight_checker
    import lsg_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    output int          mismatches,
    output int          open_results
);

    // Packed so that cell_x sits in the lowest bits of tdata.
    typedef struct packed {
        logic [POS_W-1:0]     reach;
        logic [POS_W-1:0]     to_y;
        logic [POS_W-1:0]     to_x;
        logic [POS_W-1:0]     from_y;
        logic [POS_W-1:0]     from_x;
        logic [CELL_BITS-1:0] cell_y;
        logic [CELL_BITS-1:0] cell_x;
    } shot_fields_t;

    localparam longint CELL_SPAN = longint'(1) << FRAC_BITS;

    logic [OBS_W-1:0]  cells [TABLE_DEPTH];
    int                cell_count = 0;
    logic [STEP_W-1:0] march_step = STEP_RESET;
    bit                clear_due [$];
    int                fails = 0;

    assign mismatches = fails;

    function automatic longint floor_root(longint v);
        longint r;
        longint b;
        r = 0;
        for (b = longint'(1) << 17; b != 0; b = b >> 1)
            if ((r + b) * (r + b) <= v)
                r = r + b;
        return r;
    endfunction

    // Squares are closed, so a point on any edge counts as inside.
    function automatic bit point_blocked(longint px, longint py);
        longint x0;
        longint y0;
        int     i;
        for (i = 0; i < cell_count; i++)
        begin
            x0 = longint'(cells[i][CELL_BITS-1:0]) << FRAC_BITS;
            y0 = longint'(cells[i][OBS_W-1:CELL_BITS]) << FRAC_BITS;
            if (px >= x0 && px <= x0 + CELL_SPAN && py >= y0 && py <= y0 + CELL_SPAN)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit shot_is_clear(longint fx, longint fy, longint tx, longint ty,
                                         longint reach);
        longint dx;
        longint dy;
        longint seg_len;
        longint stride;
        longint t;
        dx = tx - fx;
        dy = ty - fy;
        seg_len = floor_root(dx * dx + dy * dy);
        stride = (march_step == '0) ? longint'(1) : longint'(march_step);
        if (seg_len > reach)
            return 1'b0;
        for (t = 0; t < seg_len; t += stride)
            if (point_blocked(fx + (dx * t) / seg_len, fy + (dy * t) / seg_len))
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic flag(string what);
        fails++;
        if (fails <= 10)
            $display("[%0t] %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        shot_fields_t f;
        bit           want;
        if (!rst_n)
        begin
            cell_count = 0;
            march_step = STEP_RESET;
            clear_due.delete();
            open_results <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (clear_due.size() == 0)
                    flag($sformatf("result 0x%02h arrived with no query outstanding",
                                   m_tdata));
                else
                begin
                    want = clear_due.pop_front();
                    if (m_tdata != 8'(want))
                        flag($sformatf("shot_clear mismatch: expected 0x%02h, got 0x%02h",
                                       8'(want), m_tdata));
                end
            end

            if (cfg_wr_en)
                march_step = cfg_wr_data;

            if (s_tvalid && s_tready)
            begin
                f = shot_fields_t'(s_tdata);
                case (s_tuser)
                    MODE_LOAD:
                        if (cell_count < TABLE_DEPTH)
                        begin
                            cells[cell_count] = {f.cell_y, f.cell_x};
                            cell_count++;
                        end
                    MODE_CLEAR:
                        cell_count = 0;
                    MODE_QUERY:
                        clear_due.push_back(shot_is_clear(f.from_x, f.from_y, f.to_x,
                                                          f.to_y, f.reach));
                    default:
                        ;
                endcase
            end

            open_results <= clear_due.size();
        end
    end

endmodule

/* bench/tb_line_of_sight_grid_check_core.sv */
// Testbench top for line_of_sight_grid_check_core: drives directed and random obstacle
// loads, clears and queries under several march steps, with random stalls on both sides.
// Depends on lsg_pkg, the core RTL and lsg_sight_checker, which does all the comparing.
`timescale 1ns / 100ps

module tb_line_of_sight_grid_check_core;

    import lsg_pkg::*;

    localparam int         TABLE_DEPTH = 256;
    localparam int         CYCLE_LIMIT = 4_000_000;
    localparam int         HOLD_CYCLES = 3000;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = MODE_LOAD;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    int mismatches;
    int open_results;
    bit steady = 1'b0;
    int hold_requests = 0;
    int holds_granted = 0;
    int hold_left = 0;
    int cycles = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    line_of_sight_grid_check_core #(
        .MAX_OBSTACLES(TABLE_DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    lsg_sight_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .open_results(open_results)
    );

    // Result side: a requested hold-off blocks the output for a long stretch so that
    // the block backs up and stalls its input; otherwise ready drops about a quarter
    // of the time, unless steady is set.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_granted != hold_requests)
        begin
            m_tready <= 1'b0;
            holds_granted <= holds_granted + 1;
            hold_left <= HOLD_CYCLES;
        end
        else
            m_tready <= steady || ($urandom_range(99, 0) >= 25);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [15:0] pos16(int v);
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic logic [7:0] cell8(int v);
        return (v > 255) ? 8'hFF : 8'(v);
    endfunction

    // Called at a rising edge; returns at the edge where the transaction was taken.
    task automatic send_item(logic [1:0] kind, logic [7:0] cx, logic [7:0] cy,
                             logic [15:0] fx, logic [15:0] fy, logic [15:0] tx,
                             logic [15:0] ty, logic [15:0] rch);
        if (!steady)
            while ($urandom_range(99, 0) < 25)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {rch, ty, tx, fy, fx, cy, cx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_load(logic [7:0] cx, logic [7:0] cy);
        send_item(MODE_LOAD, cx, cy, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
    endtask

    task automatic send_query(logic [15:0] fx, logic [15:0] fy, logic [15:0] tx,
                              logic [15:0] ty, logic [15:0] rch);
        send_item(MODE_QUERY, 8'($urandom), 8'($urandom), fx, fy, tx, ty, rch);
    endtask

    task automatic send_clear();
        send_item(MODE_CLEAR, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // Waits until every answer is back; loads and clears complete when accepted.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (open_results != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_step(logic [7:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random query with both ends inside a square window of span cells.
    task automatic region_query(int ox, int oy, int span);
        logic [15:0] fx;
        logic [15:0] fy;
        logic [15:0] tx;
        logic [15:0] ty;
        logic [15:0] rch;
        int          pick;
        fx = pos16(ox * 256 + $urandom_range(span * 256, 0));
        fy = pos16(oy * 256 + $urandom_range(span * 256, 0));
        tx = pos16(ox * 256 + $urandom_range(span * 256, 0));
        ty = pos16(oy * 256 + $urandom_range(span * 256, 0));
        if ($urandom_range(19, 0) == 0)
        begin
            tx = fx;
            ty = fy;
        end
        pick = $urandom_range(99, 0);
        if (pick < 15)
            rch = 16'($urandom_range(4095, 0));
        else if (pick < 25)
            rch = 16'($urandom_range(65535, 0));
        else
            rch = 16'hFFFF;
        send_query(fx, fy, tx, ty, rch);
    endtask

    // Mostly queries through a small cluster of obstacles, with scattered loads, clears
    // and unused-mode noise mixed in.
    task automatic region_phase(int n_items, int span);
        int ox;
        int oy;
        int done;
        int roll;
        int k;
        ox = $urandom_range(255, 0);
        oy = $urandom_range(255, 0);
        send_clear();
        done = 1;
        for (k = $urandom_range(10, 2); k > 0; k--)
        begin
            send_load(cell8(ox + $urandom_range(span, 0)), cell8(oy + $urandom_range(span, 0)));
            done++;
        end
        while (done < n_items)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 12)
                send_load(cell8(ox + $urandom_range(span, 0)),
                          cell8(oy + $urandom_range(span, 0)));
            else if (roll < 15)
                send_clear();
            else if (roll < 18)
                send_item(MODE_UNUSED, 8'($urandom), 8'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else if (roll < 22)
                send_load(8'($urandom), 8'($urandom));
            else
                region_query(ox, oy, span);
            if (roll < 15 || roll >= 18)
                done++;
        end
    endtask

    initial
    begin
        int ox;
        int oy;
        int k;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset step.
        send_query(16'h8080, 16'h8080, 16'h8080, 16'h8080, 16'h0000);
        send_query(16'h0000, 16'h0000, 16'h0A00, 16'h0000, 16'h09FF);
        send_query(16'h0000, 16'h0000, 16'h0300, 16'h0400, 16'h0500);
        send_load(8'h00, 8'h00);
        send_load(8'hFF, 8'hFF);
        send_load(8'h03, 8'h03);
        send_load(8'hA5, 8'h5A);
        send_item(MODE_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF);
        send_query(16'h0100, 16'h0380, 16'h0700, 16'h0380, 16'hFFFF);
        // Runs exactly along the right edge of cell (3,3), then one LSB outside it.
        send_query(16'h0400, 16'h0100, 16'h0400, 16'h0700, 16'hFFFF);
        send_query(16'h0401, 16'h0100, 16'h0401, 16'h0700, 16'hFFFF);
        send_query(16'hFF00, 16'hFF00, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_query(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
        send_query(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_query(16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_clear();
        send_query(16'h0100, 16'h0380, 16'h0700, 16'h0380, 16'hFFFF);
        send_load(8'h03, 8'h03);
        send_query(16'h0100, 16'h0380, 16'h0700, 16'h0380, 16'hFFFF);

        write_step(8'hFF);
        region_phase(40, 12);

        // A zero step marches one LSB at a time, so these windows stay small.
        write_step(8'h00);
        region_phase(30, 2);
        write_step(8'h01);
        region_phase(30, 2);

        // Fill the table past its depth; the extra loads must be dropped.
        write_step(STEP_RESET);
        send_clear();
        ox = $urandom_range(235, 0);
        oy = $urandom_range(235, 0);
        for (k = 0; k < TABLE_DEPTH + 4; k++)
            send_load(8'(ox + $urandom_range(19, 0)), 8'(oy + $urandom_range(19, 0)));
        for (k = 0; k < 20; k++)
            region_query(ox - (ox > 2 ? 2 : ox), oy - (oy > 2 ? 2 : oy), 24);

        write_step(8'($urandom_range(254, 8)));
        hold_requests <= hold_requests + 1;
        region_phase(40, 12);

        write_step(8'h5A);
        steady <= 1'b1;
        region_phase(40, 12);
        settle();
        steady <= 1'b0;

        write_step(8'($urandom_range(255, 16)));
        region_phase(60, 6);

        settle();
        repeat (400) @(posedge clk);
        if (mismatches == 0 && open_results == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lsg_pkg.sv
hw/rtl/lsg_cell.sv
hw/rtl/lsg_root.sv
hw/rtl/lsg_div.sv
hw/rtl/line_of_sight_grid_check_core.sv
bench/lsg_sight_checker.sv
bench/tb_line_of_sight_grid_check_core.sv
